>>> rtl/core/lfga_pkg.sv
`timescale 1ns / 1ps

package lfga_pkg;

    localparam int TIME_W  = 32;
    localparam int TALLY_W = 32;
    localparam int GIDX_W  = 6;
    localparam int ENTRY_W = TIME_W + TALLY_W;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // one request transaction as it travels from front to back
    typedef struct packed {
        logic              new_batch;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] departure_time;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [GIDX_W-1:0]  gate_index;
        logic               opened_new;
        logic [TALLY_W-1:0] gate_tally;
        logic               rejected;
    } result_t;

    // back end status seen by the top level
    typedef struct packed {
        logic busy;
        logic start;
    } back_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_CHECK,
        BK_OPEN
    } back_state_t;

endpackage

>>> rtl/core/lfga_ram.sv
`timescale 1ns / 1ps

module lfga_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/lfga_front.sv
`timescale 1ns / 1ps

module lfga_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  lfga_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_pop,
    output lfga_pkg::item_t q_item
);

    import lfga_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/core/lfga_back.sv
`timescale 1ns / 1ps

module lfga_back #(
    parameter int NUM_GATES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  lfga_pkg::item_t       q_item,
    output logic                  res_valid,
    input  logic                  res_pop,
    output lfga_pkg::result_t     res,
    output lfga_pkg::back_status_t status
);

    import lfga_pkg::*;

    localparam int IDX_W = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
    localparam int CNT_W = $clog2(NUM_GATES + 1);
    localparam int EXT_W = (IDX_W > GIDX_W) ? IDX_W : GIDX_W;
    localparam logic [CNT_W-1:0] GATES_MAX = CNT_W'(NUM_GATES);

    back_state_t        state_reg, state_next;
    logic [TIME_W-1:0]  arr_reg, arr_next;
    logic [TIME_W-1:0]  dep_reg, dep_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic [CNT_W-1:0]   open_reg, open_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic               start;
    logic [TIME_W-1:0]  rd_busy;
    logic [TALLY_W-1:0] rd_tally;
    logic [TALLY_W-1:0] tally_inc;
    logic               gate_free;
    logic [CNT_W-1:0]   scan_inc;
    logic               scan_last;
    logic [CNT_W-1:0]   start_limit;
    logic [EXT_W-1:0]   scan_ext;
    logic [EXT_W-1:0]   limit_ext;

    // gate entries: departure time in the upper half, tally in the lower half
    lfga_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_GATES)
    ) u_gate_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // decode of the entry under test
    assign rd_busy     = rd_data[ENTRY_W-1:TALLY_W];
    assign rd_tally    = rd_data[TALLY_W-1:0];
    assign tally_inc   = (rd_tally == TALLY_MAX) ? rd_tally : rd_tally + 1'b1;
    assign gate_free   = (rd_busy < arr_reg);
    assign scan_inc    = CNT_W'(scan_reg + 1'b1);
    assign scan_last   = (scan_inc == limit_reg);
    assign start       = (state_reg == BK_IDLE) && q_valid && !res_valid_reg;
    assign start_limit = q_item.new_batch ? '0 : open_reg;
    assign scan_ext    = EXT_W'(scan_reg);
    assign limit_ext   = EXT_W'(limit_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    state_next = (start_limit == '0) ? BK_OPEN : BK_ISSUE;
                end
            end
            BK_ISSUE:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (gate_free)
                begin
                    state_next = BK_IDLE;
                end
                else if (scan_last)
                begin
                    state_next = BK_OPEN;
                end
                else
                begin
                    state_next = BK_ISSUE;
                end
            end
            BK_OPEN:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = scan_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = scan_reg[IDX_W-1:0];
        wr_data        = {dep_reg, tally_inc};
        arr_next       = arr_reg;
        dep_next       = dep_reg;
        scan_next      = scan_reg;
        limit_next     = limit_reg;
        open_next      = open_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    q_pop      = 1'b1;
                    arr_next   = q_item.arrival_time;
                    dep_next   = q_item.departure_time;
                    scan_next  = '0;
                    limit_next = start_limit;
                    open_next  = start_limit;
                end
            end
            BK_ISSUE:
            begin
                rd_en = 1'b1;
            end
            BK_CHECK:
            begin
                if (gate_free)
                begin
                    wr_en          = 1'b1;
                    res_valid_next = 1'b1;
                    res_next       = '{gate_index: scan_ext[GIDX_W-1:0], opened_new: 1'b0,
                                       gate_tally: tally_inc, rejected: 1'b0};
                end
                else
                begin
                    scan_next = scan_inc;
                end
            end
            BK_OPEN:
            begin
                res_valid_next = 1'b1;
                if (limit_reg < GATES_MAX)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = limit_reg[IDX_W-1:0];
                    wr_data   = {dep_reg, TALLY_W'(1)};
                    open_next = CNT_W'(limit_reg + 1'b1);
                    res_next  = '{gate_index: limit_ext[GIDX_W-1:0], opened_new: 1'b1,
                                  gate_tally: TALLY_W'(1), rejected: 1'b0};
                end
                else
                begin
                    res_next = '{gate_index: '0, opened_new: 1'b0,
                                 gate_tally: '0, rejected: 1'b1};
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            open_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        arr_reg   <= arr_next;
        dep_reg   <= dep_next;
        scan_reg  <= scan_next;
        limit_reg <= limit_next;
        res_reg   <= res_next;
    end

    assign res_valid    = res_valid_reg;
    assign res          = res_reg;
    assign status.busy  = (state_reg != BK_IDLE);
    assign status.start = start;

endmodule

>>> rtl/core/lowest_free_gate_allocator.sv
`timescale 1ns / 1ps

// Assigns each request to the lowest-numbered open gate whose stored
// departure time is below the request's arrival, opening the next gate when
// none is free and rejecting the request when all NUM_GATES gates are open and
// busy. A two-entry input queue takes requests while the back end works, and a
// one-entry result register holds the answer until it is popped. The back end
// scans the open gates one at a time through the single read port of the gate
// memory, with an issue state and a check state for each gate. A new batch
// empties the open gate count, so no clearing pass runs after reset.
module lowest_free_gate_allocator #(
    parameter int NUM_GATES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        new_batch,
    input  logic [31:0] arrival_time,
    input  logic [31:0] departure_time,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  gate_index,
    output logic        opened_new,
    output logic [31:0] gate_tally,
    output logic        rejected
);

    import lfga_pkg::*;

    item_t        in_item;
    item_t        q_item;
    logic         q_valid;
    logic         q_pop;
    logic         res_valid;
    result_t      res;
    back_status_t status;

    assign in_item = '{new_batch: new_batch, arrival_time: arrival_time,
                       departure_time: departure_time};

    // request queue
    lfga_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .in_item(in_item),
        .q_valid(q_valid),
        .q_pop  (q_pop),
        .q_item (q_item)
    );

    // gate search and result register
    lfga_back #(
        .NUM_GATES(NUM_GATES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .res_valid(res_valid),
        .res_pop  (pop),
        .res      (res),
        .status   (status)
    );

    assign empty      = !res_valid;
    assign gate_index = res.gate_index;
    assign opened_new = res.opened_new;
    assign gate_tally = res.gate_tally;
    assign rejected   = res.rejected;

    // back end never starts a request while a result still waits
    assert property (@(posedge clk) disable iff (!rst_n)
        status.start |-> empty)
        else $error("back end started with a pending result");

    // a fresh result only comes out of a busy back end
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(status.busy))
        else $error("result appeared without back end work");

    // a rejection carries no assignment
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rejected) |-> (gate_index == 6'd0 && !opened_new && gate_tally == 32'd0))
        else $error("rejected result carries an assignment");

    // a newly opened gate has served exactly this request
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && opened_new) |-> (!rejected && gate_tally == 32'd1))
        else $error("new gate with wrong tally");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import lfga_pkg::*;

    localparam int GATE_COUNT   = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        new_batch;
    logic [31:0] arrival_time;
    logic [31:0] departure_time;
    logic        empty;
    logic        pop;
    logic [5:0]  gate_index;
    logic        opened_new;
    logic [31:0] gate_tally;
    logic        rejected;

    // gate occupancy predictor and store of pending grants
    class gate_scoreboard;
        logic [TIME_W-1:0]  busy_until_q [GATE_COUNT];
        logic [TALLY_W-1:0] tally_q [GATE_COUNT];
        int unsigned        open_count;
        result_t            pending_grants[$];
        int unsigned        mismatches;

        function new();
            clear_gates();
            mismatches = 0;
        endfunction

        function void clear_gates();
            foreach (busy_until_q[g])
            begin
                busy_until_q[g] = '0;
                tally_q[g]      = '0;
            end
            open_count = 0;
        endfunction

        function int unsigned outstanding();
            return pending_grants.size();
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100)
            begin
                $display("%0t mismatch: %s", $realtime, what);
            end
        endtask

        // work out the grant for one accepted request transaction
        function void note_request(item_t req);
            result_t grant;
            int      pick;
            bit      found;
            bit      opened;
            int      g;
            if (req.new_batch)
            begin
                clear_gates();
            end
            pick   = 0;
            found  = 1'b0;
            opened = 1'b0;
            // lowest open gate that is already free
            for (g = 0; g < open_count; g++)
            begin
                if (!found && busy_until_q[g] < req.arrival_time)
                begin
                    pick  = g;
                    found = 1'b1;
                end
            end
            // otherwise open the next unused gate
            if (!found && open_count < GATE_COUNT)
            begin
                pick   = open_count;
                open_count++;
                found  = 1'b1;
                opened = 1'b1;
            end
            grant = '0;
            if (!found)
            begin
                grant.rejected = 1'b1;
            end
            else
            begin
                busy_until_q[pick] = req.departure_time;
                if (tally_q[pick] != TALLY_MAX)
                begin
                    tally_q[pick] = tally_q[pick] + 1'b1;
                end
                grant.gate_index = pick[GIDX_W-1:0];
                grant.opened_new = opened;
                grant.gate_tally = tally_q[pick];
            end
            pending_grants.push_back(grant);
        endfunction

        // compare one popped result transaction with the oldest grant
        task check_result(result_t got);
            result_t want;
            if (pending_grants.size() == 0)
            begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending_grants.pop_front();
            if (got.gate_index !== want.gate_index)
            begin
                report($sformatf("gate_index %0d, want %0d", got.gate_index, want.gate_index));
            end
            if (got.opened_new !== want.opened_new)
            begin
                report($sformatf("opened_new %b, want %b", got.opened_new, want.opened_new));
            end
            if (got.gate_tally !== want.gate_tally)
            begin
                report($sformatf("gate_tally %0d, want %0d", got.gate_tally, want.gate_tally));
            end
            if (got.rejected !== want.rejected)
            begin
                report($sformatf("rejected %b, want %b", got.rejected, want.rejected));
            end
        endtask
    endclass

    gate_scoreboard sb;
    int unsigned    accepted;
    bit             calm;
    bit             hold_req;
    bit             hold_done;
    bit             pause_done;

    lowest_free_gate_allocator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .new_batch      (new_batch),
        .arrival_time   (arrival_time),
        .departure_time (departure_time),
        .empty          (empty),
        .pop            (pop),
        .gate_index     (gate_index),
        .opened_new     (opened_new),
        .gate_tally     (gate_tally),
        .rejected       (rejected)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // hard stop for a hung run
    initial
    begin
        #(64'd20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // wait on the clock until every grant has come back, checking only after an edge
    task automatic wait_for_results();
        do
        begin
            @(posedge clk);
        end
        while (sb.outstanding() != 0);
    endtask

    // offer one request transaction and wait for it to be taken
    task automatic offer_request(input logic nb, input logic [31:0] arr,
                                 input logic [31:0] dep);
        item_t req;
        calm = (accepted >= 800 && accepted < 1100);
        if (accepted == 300 && !hold_done)
        begin
            hold_done = 1'b1;
            hold_req  = 1'b1;
        end
        if (accepted == 1500 && !pause_done)
        begin
            pause_done = 1'b1;
            push <= 1'b0;
            wait_for_results();
        end
        else if (!calm)
        begin
            while ($urandom_range(99) < 30)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push           <= 1'b1;
        new_batch      <= nb;
        arrival_time   <= arr;
        departure_time <= dep;
        req.new_batch      = nb;
        req.arrival_time   = arr;
        req.departure_time = dep;
        do
        begin
            @(posedge clk);
        end
        while (full);
        sb.note_request(req);
        accepted++;
    endtask

    // one random batch: mostly ordered arrivals, some noise and disorder
    task automatic run_batch();
        int unsigned len;
        int unsigned step_max;
        int unsigned dur_max;
        int unsigned kind;
        int unsigned k;
        logic [31:0] arr;
        logic [31:0] dep;
        logic [32:0] sum;
        logic        nb;
        kind = $urandom_range(99);
        // noise transaction with arbitrary fields
        if (kind < 10)
        begin
            offer_request($urandom_range(7) == 0, $urandom, $urandom);
            return;
        end
        if (kind < 25)
        begin
            // all arrive together: gates open one after another, rejections once all are open
            len      = $urandom_range(80, 40);
            step_max = 0;
            dur_max  = 1000;
        end
        else
        begin
            len      = ($urandom_range(9) == 0) ? $urandom_range(150, 60)
                                                : $urandom_range(40, 1);
            step_max = $urandom_range(6);
            dur_max  = $urandom_range(300);
        end
        case ($urandom_range(3))
            0:       arr = $urandom;
            1:       arr = 32'hFFFF_FFFF - $urandom_range(2000);
            default: arr = $urandom_range(1000);
        endcase
        nb = ($urandom_range(9) != 0);
        for (k = 0; k < len; k++)
        begin
            if (k > 0)
            begin
                sum = {1'b0, arr} + $urandom_range(step_max);
                arr = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            // occasional arrival out of order
            if ($urandom_range(19) == 0)
            begin
                arr = arr - $urandom_range(64);
            end
            dep = arr + $urandom_range(dur_max);
            // occasional departure before arrival
            if ($urandom_range(19) == 0)
            begin
                dep = arr - $urandom_range(64);
            end
            offer_request(nb && (k == 0), arr, dep);
        end
    endtask

    // result side: random pops, one long hold-off
    initial
    begin
        result_t     got;
        int unsigned hold_left;
        pop       <= 1'b0;
        hold_left = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (calm)
            begin
                pop <= 1'b1;
            end
            else
            begin
                pop <= ($urandom_range(99) >= 30);
            end
            @(posedge clk);
            if (pop && !empty)
            begin
                got.gate_index = gate_index;
                got.opened_new = opened_new;
                got.gate_tally = gate_tally;
                got.rejected   = rejected;
                sb.check_result(got);
            end
        end
    end

    // stimulus
    initial
    begin
        sb             = new();
        accepted       = 0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        rst_n          <= 1'b0;
        push           <= 1'b0;
        new_batch      <= 1'b0;
        arrival_time   <= '0;
        departure_time <= '0;
        repeat (8)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, ties, disorder, wrapped departures
        offer_request(1'b1, 32'h0000_0000, 32'h0000_0000);
        offer_request(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(1'b0, 32'h0000_0001, 32'h0000_0005);
        offer_request(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(1'b0, 32'h0000_0003, 32'h0000_000A);
        offer_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(1'b0, 32'hFFFF_FFFF, 32'h0000_0001);
        offer_request(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        offer_request(1'b0, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        offer_request(1'b0, 32'hA5A5_A5A6, 32'hFFFF_FFFE);
        offer_request(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        offer_request(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        offer_request(1'b0, 32'h8000_0000, 32'h8000_0000);
        offer_request(1'b0, 32'h8000_0001, 32'h0000_0000);

        // random batches
        while (accepted < RANDOM_ITEMS + 15)
        begin
            run_batch();
        end

        // let the block drain, then watch for stray results
        push <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (sb.outstanding() != 0)
        begin
            sb.report($sformatf("%0d grants never came back", sb.outstanding()));
        end
        if (sb.mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
